[rtl/apzc_pkg.sv]
// Package of the average-predict zigzag coder.
// Holds the shared widths, register indexes, control structs and the zigzag functions.
// No dependencies.
package apzc_pkg;

	localparam int MAX_ROW_BLOCKS = 1024;
	localparam int MAX_FIELD_BITS = 32;
	localparam int FIELD_W        = 32;
	localparam int FIELD_BITS_W   = 6;
	localparam int ROWLEN_W       = $clog2(MAX_ROW_BLOCKS) + 1;
	localparam int COL_W          = $clog2(MAX_ROW_BLOCKS);
	localparam int CFG_DATA_W     = 11;
	localparam int CFG_INDEX_W    = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIELD_BITS     = 2'd0,
		REG_BLOCKS_PER_ROW = 2'd1,
		REG_DELTA_ENABLE   = 2'd2,
		REG_DECODE_MODE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_BITS_W-1:0] field_bits;
		logic [ROWLEN_W-1:0]     blocks_per_row;
		logic                    delta_enable;
		logic                    decode_mode;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             first_row;
		logic             start;
	} pos_t;

	function automatic logic [FIELD_W-1:0] width_mask(input logic [FIELD_BITS_W-1:0] bits);
		logic [FIELD_W-1:0] m;
		if (bits >= FIELD_BITS_W'(MAX_FIELD_BITS)) begin
			m = '1;
		end else begin
			m = (FIELD_W'(1) << bits) - FIELD_W'(1);
		end
		return m;
	endfunction

	function automatic logic [FIELD_W-1:0] zig_encode(input logic [FIELD_W-1:0] d,
			input logic [FIELD_W-1:0] mask);
		logic [FIELD_W-1:0] u;
		logic [FIELD_W-1:0] sign;
		logic [FIELD_W-1:0] flip;
		u    = d & mask;
		sign = mask ^ (mask >> 1);
		flip = (|(u & sign)) ? mask : '0;
		return ((u << 1) ^ flip) & mask;
	endfunction

	function automatic logic [FIELD_W-1:0] zig_decode(input logic [FIELD_W-1:0] z,
			input logic [FIELD_W-1:0] mask);
		logic [FIELD_W-1:0] u;
		u = z & mask;
		return u[0] ? ~(u >> 1) : (u >> 1);
	endfunction

endpackage

[rtl/apzc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// A read at the address being written returns the old contents. No dependencies.
module apzc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/apzc_pos.sv]
// Row position tracker: column and first-row flag of each incoming request.
// Depends on apzc_pkg.
module apzc_pos import apzc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                start,
	input  logic [ROWLEN_W-1:0] blocks_per_row,
	output pos_t                pos
);

	logic [COL_W-1:0]    col_q;
	logic                first_q;
	logic [ROWLEN_W-1:0] row_len;
	logic [ROWLEN_W-1:0] col_next;

	always_comb begin
		if (blocks_per_row == '0) begin
			row_len = ROWLEN_W'(1);
		end else if (blocks_per_row > ROWLEN_W'(MAX_ROW_BLOCKS)) begin
			row_len = ROWLEN_W'(MAX_ROW_BLOCKS);
		end else begin
			row_len = blocks_per_row;
		end
		pos.start     = start;
		pos.col       = start ? '0 : col_q;
		pos.first_row = start ? 1'b1 : first_q;
		col_next      = ROWLEN_W'(pos.col) + ROWLEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (col_next >= row_len) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col_next[COL_W-1:0];
				first_q <= pos.first_row;
			end
		end
	end

endmodule

[rtl/apzc_pred.sv]
// Prediction and zigzag datapath: averages left and top; gives residual, decoded or raw.
// Purely combinational. Depends on apzc_pkg.
module apzc_pred import apzc_pkg::*; (
	input  cfg_t               cfg,
	input  logic [FIELD_W-1:0] value,
	input  logic               start,
	input  logic               first_row,
	input  logic [FIELD_W-1:0] left,
	input  logic [FIELD_W-1:0] top_stored,
	output logic [FIELD_W-1:0] raw,
	output logic [FIELD_W-1:0] result
);

	logic [FIELD_W-1:0] mask;
	logic [FIELD_W-1:0] v;
	logic [FIELD_W-1:0] left_eff;
	logic [FIELD_W-1:0] top;
	logic [FIELD_W-1:0] sum;
	logic [FIELD_W-1:0] avg;

	always_comb begin
		mask     = width_mask(cfg.field_bits);
		v        = value & mask;
		left_eff = start ? '0 : left;
		top      = first_row ? left_eff : top_stored;
		sum      = left_eff + top;
		avg      = sum >> 1;
		if (!cfg.delta_enable) begin
			raw    = v;
			result = v;
		end else if (cfg.decode_mode) begin
			raw    = (avg + zig_decode(v, mask)) & mask;
			result = raw;
		end else begin
			raw    = v;
			result = zig_encode(v - avg, mask);
		end
	end

endmodule

[rtl/average_predict_zigzag_coder_unit.sv]
// Top level of the average-predict zigzag coder.
// Instantiates apzc_pos, apzc_ram and apzc_pred; depends on apzc_pkg.
//
// The unit takes one field value per texture block in raster order and returns one
// coded value per request, one request per clock cycle sustained while the output is not
// stalled. A request is held in the input stage, where the previous row's value is read
// from a 1024-entry row RAM, and is then coded and placed in the output register, from
// which its result is presented. A stalled output holds the request in the input stage
// until the output register can take it. The row RAM needs no clearing after reset. The
// user must write configuration only while the unit is idle; the unit does not enforce it.
module average_predict_zigzag_coder_unit import apzc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [FIELD_W-1:0]     s_axis_tdata,  // [31:0] field_value
	input  logic                   s_axis_tuser,  // [0] stream_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [FIELD_W-1:0]     m_axis_tdata,  // [31:0] coded_value
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t               cfg_q;
	pos_t               pos;
	logic               in_accept;
	logic               advance;
	logic               valid_s1;
	logic [FIELD_W-1:0] value_s1;
	pos_t               pos_s1;
	logic               byp_s1;
	logic [FIELD_W-1:0] byp_data_s1;
	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] ram_rdata;
	logic [FIELD_W-1:0] top_stored;
	logic [FIELD_W-1:0] raw;
	logic [FIELD_W-1:0] result;
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_data_q;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign top_stored    = byp_s1 ? byp_data_s1 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_bits     <= FIELD_BITS_W'(MAX_FIELD_BITS);
			cfg_q.blocks_per_row <= ROWLEN_W'(1);
			cfg_q.delta_enable   <= 1'b1;
			cfg_q.decode_mode    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FIELD_BITS:     cfg_q.field_bits     <= cfg_data[FIELD_BITS_W-1:0];
				REG_BLOCKS_PER_ROW: cfg_q.blocks_per_row <= cfg_data[ROWLEN_W-1:0];
				REG_DELTA_ENABLE:   cfg_q.delta_enable   <= cfg_data[0];
				REG_DECODE_MODE:    cfg_q.decode_mode    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	apzc_pos u_pos (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_accept),
		.start          (s_axis_tuser),
		.blocks_per_row (cfg_q.blocks_per_row),
		.pos            (pos)
	);

	apzc_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (MAX_ROW_BLOCKS)
	) u_row_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (pos_s1.col),
		.wdata (raw),
		.re    (in_accept),
		.raddr (pos.col),
		.rdata (ram_rdata)
	);

	apzc_pred u_pred (
		.cfg        (cfg_q),
		.value      (value_s1),
		.start      (pos_s1.start),
		.first_row  (pos_s1.first_row),
		.left       (left_q),
		.top_stored (top_stored),
		.raw        (raw),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// The row RAM returns old data when the request leaving the input stage writes
	// the same column, so that value is forwarded.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_s1    <= s_axis_tdata;
			pos_s1      <= pos;
			byp_s1      <= advance && (pos_s1.col == pos.col);
			byp_data_s1 <= raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (advance) begin
			left_q <= raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result & width_mask(cfg_q.field_bits);
		end
	end

endmodule

[rtl/apzc_checker.sv]
// Port-level checker of the coder unit, bound to the top level.
// Depends on apzc_pkg and average_predict_zigzag_coder_unit.
module apzc_checker import apzc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [FIELD_W-1:0] m_axis_tdata
);

	logic out_stall;
	logic in_accept;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result changed or dropped while stalled.");

	a_block_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input blocked while the output register is empty.");

	a_fill_then_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_stall && in_accept) ##1 out_stall |-> !s_axis_tready)
		else $error("Input accepted with both stages full.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("Accepted request produced no result.");

endmodule

bind average_predict_zigzag_coder_unit apzc_checker u_apzc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
